// ===== src/prc_pkg.sv =====
`default_nettype none

package prc_pkg;

   // Field widths fixed by the interface
   localparam int ROUTE_SLOTS = 4;
   localparam int BYTE_W      = 8;
   localparam int PAT_W       = 56;
   localparam int LEN_W       = 3;
   localparam int PORT_W      = 4;
   localparam int IDX_W       = 2;
   localparam int POS_W       = 3;
   localparam int POS_MAX     = 7;
   localparam int CSR_IDX_W   = 4;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_0       = 4'd0,
      CSR_PATTERN_1       = 4'd1,
      CSR_PATTERN_2       = 4'd2,
      CSR_PATTERN_3       = 4'd3,
      CSR_ROUTE_LENGTHS   = 4'd4,
      CSR_ROUTE_PORTS     = 4'd5,
      CSR_FALLBACK_ENABLE = 4'd6,
      CSR_FALLBACK_PORT   = 4'd7
   } csr_index_type;

   // Routing table as seen by the matcher
   typedef struct packed {
      logic [ROUTE_SLOTS-1:0][PAT_W-1:0]  patterns;
      logic [ROUTE_SLOTS-1:0][LEN_W-1:0]  lengths;
      logic [ROUTE_SLOTS-1:0][PORT_W-1:0] ports;
      logic                               fallback_enable;
      logic [PORT_W-1:0]                  fallback_port;
   } cfg_type;

   // One byte beat held in the input register
   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] data;
      logic              last;
   } stage_type;

   // Routing decision for a finished message
   typedef struct packed {
      logic              deliver;
      logic [PORT_W-1:0] out_port;
      logic              route_hit;
      logic [IDX_W-1:0]  hit_index;
   } result_type;

endpackage

`default_nettype wire

// ===== src/prefix_route_classifier.sv =====
`default_nettype none

// Channel   Direction  Handshake                Payload
// req_      in         req_valid / req_ready    message_byte, end_of_message
// rsp_      out        rsp_valid / rsp_ready    deliver, out_port, route_hit, hit_index
// csr_      in         csr_valid / csr_ready    csr_index, csr_data
//
// One byte per cycle while no last byte is held back; a byte is matched in the cycle after its accept edge,
// so a last byte's result beat is loaded into the result register as it leaves the input register.
// Only the last byte of a message produces a result beat; others only advance the match state.
// Reset clears the routing table to zero and restarts the message.
// A full, stalled result register holds a last byte in the input register and
// drops req_ready; other bytes keep flowing under it.
// csr_ready is always high; each write is registered into the routing table.

module prefix_route_classifier
   import prc_pkg::*;
#(
   parameter int NUM_ROUTES        = 4,
   parameter int MAX_PATTERN_BYTES = 7
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [BYTE_W-1:0]    req_message_byte,
   input  wire logic                 req_end_of_message,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_deliver,
   output logic [PORT_W-1:0]         rsp_out_port,
   output logic                      rsp_route_hit,
   output logic [IDX_W-1:0]          rsp_hit_index,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [PAT_W-1:0]     csr_data
);

   cfg_type    cfg;
   stage_type  stage;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, take, finish;

   assign csr_ready = 1'b1;

   prc_csr u_csr (
      .clock (clock),
      .reset (reset),
      .write (csr_valid && csr_ready),
      .index (csr_index),
      .data  (csr_data),
      .cfg   (cfg)
   );

   prc_input_stage u_input (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_message_byte   (req_message_byte),
      .req_end_of_message (req_end_of_message),
      .take               (take),
      .stage              (stage)
   );

   // Advance the held byte unless it is last and the result slot is full
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign take     = stage.valid && (!stage.last || out_free);
   assign finish   = take && stage.last;

   prc_matcher #(
      .NUM_ROUTES        (NUM_ROUTES),
      .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
   ) u_matcher (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (take),
      .data   (stage.data),
      .last   (stage.last),
      .result (result)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else
         rsp_valid_ff <= rsp_valid_in;
   end

   always_ff @(posedge clock) begin
      if (finish)
         rsp_ff <= result;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_deliver   = rsp_ff.deliver;
   assign rsp_out_port  = rsp_ff.out_port;
   assign rsp_route_hit = rsp_ff.route_hit;
   assign rsp_hit_index = rsp_ff.hit_index;

   a_drop_is_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_deliver |-> rsp_out_port == '0 && !rsp_route_hit)
      else $error("dropped message carries a port or a hit");

   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_route_hit |-> rsp_hit_index == '0)
      else $error("hit index set without a route hit");

   a_mid_byte_no_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(stage.valid && stage.last) |=> !rsp_valid_ff)
      else $error("result beat without a last byte");

endmodule

`default_nettype wire

// ===== src/prc_csr.sv =====
`default_nettype none

module prc_csr
   import prc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 write,
   input  wire logic [CSR_IDX_W-1:0] index,
   input  wire logic [PAT_W-1:0]     data,
   output cfg_type                   cfg
);

   cfg_type cfg_ff;

   // Decode the write beat; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (write) begin
         case (index)
            CSR_PATTERN_0:       cfg_ff.patterns[0]     <= data;
            CSR_PATTERN_1:       cfg_ff.patterns[1]     <= data;
            CSR_PATTERN_2:       cfg_ff.patterns[2]     <= data;
            CSR_PATTERN_3:       cfg_ff.patterns[3]     <= data;
            CSR_ROUTE_LENGTHS:   cfg_ff.lengths         <= data[ROUTE_SLOTS*LEN_W-1:0];
            CSR_ROUTE_PORTS:     cfg_ff.ports           <= data[ROUTE_SLOTS*PORT_W-1:0];
            CSR_FALLBACK_ENABLE: cfg_ff.fallback_enable <= data[0];
            CSR_FALLBACK_PORT:   cfg_ff.fallback_port   <= data[PORT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== src/prc_input_stage.sv =====
`default_nettype none

module prc_input_stage
   import prc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [BYTE_W-1:0] req_message_byte,
   input  wire logic              req_end_of_message,
   input  wire logic              take,
   output stage_type              stage
);

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] data_ff;
   logic              last_ff;
   logic              load;

   // Accept a new beat when the register is empty or the held one leaves this cycle
   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load)
         valid_in = 1'b1;
      else if (take)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_message_byte;
         last_ff <= req_end_of_message;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.data  = data_ff;
   assign stage.last  = last_ff;

endmodule

`default_nettype wire

// ===== src/prc_matcher.sv =====
`default_nettype none

module prc_matcher
   import prc_pkg::*;
#(
   parameter int NUM_ROUTES        = 4,
   parameter int MAX_PATTERN_BYTES = 7
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  cfg_type                cfg,
   input  wire logic              step,
   input  wire logic [BYTE_W-1:0] data,
   input  wire logic              last,
   output result_type             result
);

   logic [ROUTE_SLOTS-1:0] alive_ff, alive_in;
   logic [ROUTE_SLOTS-1:0] hit_mask_ff, hit_mask_in;
   logic [POS_W-1:0]       pos_ff, pos_in;

   logic [ROUTE_SLOTS-1:0]            alive_next;
   logic [ROUTE_SLOTS-1:0]            hit_next;
   logic [ROUTE_SLOTS-1:0][LEN_W-1:0] len_eff;
   logic [IDX_W-1:0]                  hit_idx;

   // Compare this byte against every active route in parallel
   always_comb begin
      logic [POS_MAX:0][BYTE_W-1:0] pat_view;
      alive_next = alive_ff;
      hit_next   = hit_mask_ff;
      len_eff    = '0;
      for (int r = 0; r < ROUTE_SLOTS; r++) begin
         pat_view = {BYTE_W'(0), cfg.patterns[r]};
         if (r < NUM_ROUTES) begin
            len_eff[r] = cfg.lengths[r];
            if (len_eff[r] > LEN_W'(MAX_PATTERN_BYTES))
               len_eff[r] = LEN_W'(MAX_PATTERN_BYTES);
            if (len_eff[r] != '0 && pos_ff < len_eff[r]) begin
               if (pat_view[pos_ff] != data)
                  alive_next[r] = 1'b0;
               if (pos_ff + POS_W'(1) == len_eff[r] && alive_next[r])
                  hit_next[r] = 1'b1;
            end
         end
      end
   end

   // Lowest matching route wins
   always_comb begin
      hit_idx = '0;
      for (int r = ROUTE_SLOTS - 1; r >= 0; r--) begin
         if (hit_next[r])
            hit_idx = IDX_W'(r);
      end
   end

   // Build the decision from the state after this byte
   always_comb begin
      result = '0;
      if (hit_next != '0) begin
         result.deliver   = 1'b1;
         result.out_port  = cfg.ports[hit_idx];
         result.route_hit = 1'b1;
         result.hit_index = hit_idx;
      end else if (cfg.fallback_enable) begin
         result.deliver  = 1'b1;
         result.out_port = cfg.fallback_port;
      end
   end

   // Advance per byte, clear after the last one
   always_comb begin
      alive_in    = alive_ff;
      hit_mask_in = hit_mask_ff;
      pos_in      = pos_ff;
      if (step) begin
         if (last) begin
            alive_in    = '1;
            hit_mask_in = '0;
            pos_in      = '0;
         end else begin
            alive_in    = alive_next;
            hit_mask_in = hit_next;
            if (pos_ff != POS_W'(POS_MAX))
               pos_in = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff    <= '1;
         hit_mask_ff <= '0;
         pos_ff      <= '0;
      end else begin
         alive_ff    <= alive_in;
         hit_mask_ff <= hit_mask_in;
         pos_ff      <= pos_in;
      end
   end

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      step && last |=> pos_ff == '0 && hit_mask_ff == '0 && alive_ff == '1)
      else $error("message state not cleared after last byte");

   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !step |=> $stable(pos_ff) && $stable(hit_mask_ff) && $stable(alive_ff))
      else $error("message state moved without a byte");

endmodule

`default_nettype wire
